FILE: hw/rtl/arp_reply_cache_learner_core_defines.svh
// ----------------------------------------------------------------------------
// arp reply cache learner assertion macros
// shared concurrent check forms used at the end of the core
// ----------------------------------------------------------------------------
`ifndef ARP_REPLY_CACHE_LEARNER_CORE_DEFINES_SVH
`define ARP_REPLY_CACHE_LEARNER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ARCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ARCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/arcl_pkg.sv
// ----------------------------------------------------------------------------
// arcl_pkg
// types and constants shared by the arp reply cache learner modules
// ----------------------------------------------------------------------------
package arcl_pkg;

   localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
   localparam logic [15:0] OPCODE_REPLY    = 16'h0002;
   localparam logic [5:0]  MIN_FRAME_BYTES = 6'd32;
   localparam logic [5:0]  POS_MAX         = 6'd63;

   // result status codes
   localparam logic [1:0] RSP_IGNORED = 2'd0;
   localparam logic [1:0] RSP_UPDATED = 2'd1;
   localparam logic [1:0] RSP_ADDED   = 2'd2;
   localparam logic [1:0] RSP_DROPPED = 2'd3;

   typedef enum logic [1:0] {
      OUT_IGNORE,
      OUT_HIT,
      OUT_MISS
   } outcome_type;

   typedef struct packed {
      logic        byte_en;
      logic        search_start;
      logic        rd_issue;
      logic        latch_hit;
      logic        commit;
      outcome_type outcome;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic issue_done;
      logic rd_vld;
      logic rd_hit;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: hw/rtl/arcl_ctrl.sv
// ----------------------------------------------------------------------------
// arcl_ctrl
// sequencer: frame intake, reply check, table search and result commit
// ----------------------------------------------------------------------------
module arcl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  arcl_pkg::dp_sts_type  sts,
   output arcl_pkg::ctl_cmd_type cmd
);
   import arcl_pkg::*;

   typedef enum logic [1:0] {
      ST_PARSE,
      ST_DECIDE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;

   always_comb begin
      state_in         = state_ff;
      outcome_in       = outcome_ff;
      req_tready       = 1'b0;
      cmd.byte_en      = 1'b0;
      cmd.search_start = 1'b0;
      cmd.rd_issue     = 1'b0;
      cmd.latch_hit    = 1'b0;
      cmd.commit       = 1'b0;
      cmd.outcome      = outcome_ff;
      case (state_ff)
         ST_PARSE: begin
            req_tready  = 1'b1;
            cmd.byte_en = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.frame_ok) begin
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end else begin
               outcome_in = OUT_IGNORE;
               state_in   = ST_COMMIT;
            end
         end
         ST_SEARCH: begin
            // one table read issued per cycle, compared in the cycle after
            cmd.rd_issue = !sts.issue_done && !sts.rd_hit;
            if (sts.rd_hit) begin
               cmd.latch_hit = 1'b1;
               outcome_in    = OUT_HIT;
               state_in      = ST_COMMIT;
            end else if (sts.issue_done && !sts.rd_vld) begin
               outcome_in = OUT_MISS;
               state_in   = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = sts.out_free;
            if (sts.out_free) begin
               state_in = ST_PARSE;
            end
         end
         default: begin
            state_in = ST_PARSE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_PARSE;
         outcome_ff <= OUT_IGNORE;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule

FILE: hw/rtl/arcl_datapath.sv
// ----------------------------------------------------------------------------
// arcl_datapath
// header capture, address table memories, search compare and result register
// ----------------------------------------------------------------------------
module arcl_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  arcl_pkg::ctl_cmd_type cmd,
   output arcl_pkg::dp_sts_type  sts,
   input  logic [7:0]            frame_byte,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [1:0]            rsp_status,
   output logic [5:0]            rsp_index,
   output logic [6:0]            rsp_count,
   output logic [31:0]           rsp_ip,
   output logic [47:0]           rsp_mac
);
   import arcl_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [31:0] ip_mem  [0:TABLE_DEPTH-1];
   logic [47:0] mac_mem [0:TABLE_DEPTH-1];

   logic [5:0]    pos_ff, pos_in;
   logic [15:0]   type_ff, type_in;
   logic [15:0]   opcode_ff, opcode_in;
   logic [47:0]   cap_mac_ff, cap_mac_in;
   logic [31:0]   cap_ip_ff, cap_ip_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff;
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] rd_tag_ff;
   logic [AW-1:0] hit_idx_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff;
   logic [5:0]    index_ff;
   logic [6:0]    count_out_ff;
   logic [31:0]   ip_out_ff;
   logic [47:0]   mac_out_ff;

   logic          room;
   logic          append;
   logic          hit_wr;
   logic [AW-1:0] wr_addr;
   logic [1:0]    status_res;
   logic [AW-1:0] idx_res;

   // header capture
   always_comb begin
      pos_in     = pos_ff;
      type_in    = type_ff;
      opcode_in  = opcode_ff;
      cap_mac_in = cap_mac_ff;
      cap_ip_in  = cap_ip_ff;
      if (cmd.commit) begin
         pos_in     = '0;
         type_in    = '0;
         opcode_in  = '0;
         cap_mac_in = '0;
         cap_ip_in  = '0;
      end else if (cmd.byte_en) begin
         case (pos_ff) inside
            [6'd12:6'd13]: type_in    = {type_ff[7:0], frame_byte};
            [6'd20:6'd21]: opcode_in  = {opcode_ff[7:0], frame_byte};
            [6'd22:6'd27]: cap_mac_in = {cap_mac_ff[39:0], frame_byte};
            [6'd28:6'd31]: cap_ip_in  = {cap_ip_ff[23:0], frame_byte};
            default: ;
         endcase
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   // position after the last byte is 32 or more exactly when the frame had at least 32 bytes
   assign sts.frame_ok = (pos_ff >= MIN_FRAME_BYTES) && (type_ff == ETHERTYPE_ARP) &&
                         (opcode_ff == OPCODE_REPLY);

   // search
   assign rd_idx_in      = cmd.search_start ? '0 :
                           (cmd.rd_issue ? rd_idx_ff + CW'(1) : rd_idx_ff);
   assign sts.issue_done = (rd_idx_ff >= count_ff);
   assign sts.rd_vld     = rd_vld_ff;
   assign sts.rd_hit     = rd_vld_ff && (rd_data_ff == cap_ip_ff);

   // commit
   assign room    = (count_ff < DEPTH_C);
   assign append  = cmd.commit && (cmd.outcome == OUT_MISS) && room;
   assign hit_wr  = cmd.commit && (cmd.outcome == OUT_HIT);
   assign wr_addr = hit_wr ? hit_idx_ff : count_ff[AW-1:0];

   always_comb begin
      case (cmd.outcome)
         OUT_HIT:  status_res = RSP_UPDATED;
         OUT_MISS: status_res = room ? RSP_ADDED : RSP_DROPPED;
         default:  status_res = RSP_IGNORED;
      endcase
   end

   assign idx_res  = hit_wr ? hit_idx_ff : (append ? count_ff[AW-1:0] : '0);
   assign count_in = append ? count_ff + CW'(1) : count_ff;

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         type_ff      <= '0;
         opcode_ff    <= '0;
         cap_mac_ff   <= '0;
         cap_ip_ff    <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         type_ff      <= type_in;
         opcode_ff    <= opcode_in;
         cap_mac_ff   <= cap_mac_in;
         cap_ip_ff    <= cap_ip_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= cmd.rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ip table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (append) begin
         ip_mem[count_ff[AW-1:0]] <= cap_ip_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= ip_mem[rd_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (append || hit_wr) begin
         mac_mem[wr_addr] <= cap_mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_tag_ff <= rd_idx_ff[AW-1:0];
      end
      if (cmd.latch_hit) begin
         hit_idx_ff <= rd_tag_ff;
      end
      if (cmd.commit) begin
         status_ff    <= status_res;
         index_ff     <= 6'(idx_res);
         count_out_ff <= 7'(count_in);
         ip_out_ff    <= (cmd.outcome == OUT_IGNORE) ? 32'd0 : cap_ip_ff;
         mac_out_ff   <= (cmd.outcome == OUT_IGNORE) ? 48'd0 : cap_mac_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_index  = index_ff;
   assign rsp_count  = count_out_ff;
   assign rsp_ip     = ip_out_ff;
   assign rsp_mac    = mac_out_ff;

endmodule

FILE: hw/rtl/arp_reply_cache_learner_core.sv
// ----------------------------------------------------------------------------
// arp_reply_cache_learner_core
// learns sender ip to mac bindings from received arp reply frames
// ----------------------------------------------------------------------------
// usage:
//   req_* carries an ethernet frame one byte per beat, req_tlast on the last
//   byte. bytes stream in at one beat per cycle while a frame is running.
//   after the last byte req_tready drops while the frame is judged and the
//   table is searched; exactly one rsp_* beat follows every frame.
//   an ignored frame goes from the decide state straight to commit; an arp
//   reply first searches the n valid table entries until a hit, and the
//   single ip table read port compares one stored entry per cycle.
//   the result sits in an output register; req_tready returns in the cycle
//   that the result appears, so a new frame streams in while the result waits.
//   a stalled receiver holds the result and, once the next frame ends, the
//   commit of that frame waits for the output register to empty.
//   reset empties the table (entry count zero) and the frame capture; no
//   clearing pass is needed, entries are only read below the count.
// ----------------------------------------------------------------------------
`include "arp_reply_cache_learner_core_defines.svh"

module arp_reply_cache_learner_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [5:0] entry_index, [12:6] entry_count,
                                    // [44:13] peer_ip, [92:45] peer_mac
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import arcl_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_sts_type  dp_sts;
   logic [5:0]  rsp_index;
   logic [6:0]  rsp_count;
   logic [31:0] rsp_ip;
   logic [47:0] rsp_mac;

   arcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (ctl_cmd)
   );

   arcl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctl_cmd),
      .sts        (dp_sts),
      .frame_byte (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_index  (rsp_index),
      .rsp_count  (rsp_count),
      .rsp_ip     (rsp_ip),
      .rsp_mac    (rsp_mac)
   );

   assign rsp_tdata = {3'd0, rsp_mac, rsp_ip, rsp_count, rsp_index};

   `ARCL_ASSERT_NOW(a_read_below_count, clock, reset, ctl_cmd.rd_issue, !dp_sts.issue_done, "table read at or above entry count")
   `ARCL_ASSERT_NEXT(a_hold_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "frame intake not paused after last byte")
   `ARCL_ASSERT_NOW(a_ignored_is_clean, clock, reset, rsp_tvalid && (rsp_tuser == RSP_IGNORED), (rsp_tdata[92:13] == 80'd0) && (rsp_tdata[5:0] == 6'd0), "ignored frame result carries data")

endmodule
